// File: design/vefc_pkg.sv
// vefc_pkg: payload types, type codes and the packed-normal unpack function
// for the vertex element format converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vefc_pkg;

  typedef enum logic [2:0] {
    KIND_COPY        = 3'd0,
    KIND_NORMSHORT3  = 3'd1,
    KIND_NORMPACKED3 = 3'd2,
    KIND_SHORT3      = 3'd3,
    KIND_PBYTE3      = 3'd4,
    KIND_FLOAT2H     = 3'd5,
    KIND_NONE        = 3'd6,
    KIND_COLOR       = 3'd7
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  src_byte_count;
    logic [31:0] src_word0;
    logic [31:0] src_word1;
    logic [31:0] src_word2;
    logic [31:0] src_word3;
  } in_item_t;

  typedef struct packed {
    logic [31:0] dst_word0;
    logic [31:0] dst_word1;
    logic [31:0] dst_word2;
    logic [31:0] dst_word3;
    logic [4:0]  dst_byte_count;
  } out_item_t;

  localparam logic [31:0] FLOAT_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FLOAT_ZERO = 32'h0000_0000;
  localparam logic [4:0]  MAX_BYTES  = 5'd16;

  // signed 11-bit (or 10-bit when narrow) component to a single float;
  // positive values over 2^(n-1)-1 form a repeating binary fraction, never a tie
  function automatic logic [31:0] unpack_comp(input logic [10:0] raw, input logic narrow);
    logic        neg;
    logic [10:0] sv;
    logic [10:0] mag;
    logic [9:0]  pv;
    logic [59:0] rep;
    logic [59:0] sh;
    logic [3:0]  lz;
    logic [3:0]  p;
    logic        found;
    logic [7:0]  ex;
    logic [24:0] rm;
    logic [22:0] mant;
    logic [33:0] nm;
    logic        all_ones;
    logic [31:0] res;
    neg  = narrow ? raw[9] : raw[10];
    sv   = narrow ? {raw[9], raw[9:0]} : raw;
    mag  = neg ? (~sv + 11'd1) : sv;
    pv   = mag[9:0];
    rep  = narrow ? {{6{pv[8:0]}}, 6'b0} : {6{pv}};
    all_ones = narrow ? (pv[8:0] == 9'h1FF) : (pv == 10'h3FF);
    lz    = 4'd0;
    found = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (!found && rep[59 - i]) begin
        lz    = 4'(i);
        found = 1'b1;
      end
    end
    p = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (mag[i]) p = 4'(i);
    end
    sh   = rep << (lz + 4'd1);
    ex   = 8'd126 - {4'd0, lz};
    rm   = {2'b01, sh[59:37]} + {24'd0, sh[36]};
    mant = rm[22:0];
    if (rm[24]) ex = ex + 8'd1;
    nm   = {23'd0, mag} << (5'd23 - {1'b0, p});
    if (mag == 11'd0) begin
      res = FLOAT_ZERO;
    end else if (neg) begin
      res = {1'b1, 8'd117 + {4'd0, p} + {7'd0, narrow}, nm[22:0]};
    end else if (all_ones) begin
      res = FLOAT_ONE;
    end else begin
      res = {1'b0, ex, mant};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: design/vefc_convert.sv
// vefc_convert: combinational conversion of one vertex element.
// Depends on vefc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vefc_convert (
  input  vefc_pkg::in_item_t  item_i,
  output vefc_pkg::out_item_t item_o
);
  import vefc_pkg::*;

  logic [4:0]   cnt;
  logic [127:0] src;
  logic [127:0] masked;
  logic [31:0]  s0;

  assign s0  = item_i.src_word0;
  assign cnt = (item_i.src_byte_count > MAX_BYTES) ? MAX_BYTES : item_i.src_byte_count;
  assign src = {item_i.src_word3, item_i.src_word2, item_i.src_word1, item_i.src_word0};

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      masked[b*8 +: 8] = (5'(b) < cnt) ? src[b*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    item_o = '0;
    unique case (kind_t'(item_i.kind))
      KIND_NORMSHORT3: begin
        item_o.dst_word0      = s0;
        item_o.dst_word1      = {16'h7FFF, item_i.src_word1[15:0]};
        item_o.dst_byte_count = 5'd8;
      end
      KIND_NORMPACKED3: begin
        item_o.dst_word0      = unpack_comp(s0[10:0], 1'b0);
        item_o.dst_word1      = unpack_comp(s0[21:11], 1'b0);
        item_o.dst_word2      = unpack_comp({1'b0, s0[31:22]}, 1'b1);
        item_o.dst_byte_count = 5'd12;
      end
      KIND_SHORT3: begin
        item_o.dst_word0      = s0;
        item_o.dst_word1      = {16'h0001, item_i.src_word1[15:0]};
        item_o.dst_byte_count = 5'd8;
      end
      KIND_PBYTE3: begin
        item_o.dst_word0      = {8'hFF, s0[23:0]};
        item_o.dst_byte_count = 5'd4;
      end
      KIND_FLOAT2H: begin
        item_o.dst_word0      = s0;
        item_o.dst_word1      = item_i.src_word1;
        item_o.dst_word2      = FLOAT_ZERO;
        item_o.dst_word3      = item_i.src_word2;
        item_o.dst_byte_count = 5'd16;
      end
      KIND_NONE: begin
        item_o.dst_byte_count = 5'd0;
      end
      KIND_COLOR: begin
        item_o.dst_word0      = {s0[31:24], s0[7:0], s0[15:8], s0[23:16]};
        item_o.dst_byte_count = 5'd4;
      end
      default: begin
        item_o.dst_word0      = masked[31:0];
        item_o.dst_word1      = masked[63:32];
        item_o.dst_word2      = masked[95:64];
        item_o.dst_word3      = masked[127:96];
        item_o.dst_byte_count = cnt;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/vertex_element_format_converter_unit.sv
// vertex_element_format_converter_unit: top level, input register, converter
// and result register. Depends on vefc_pkg and vefc_convert.
`timescale 1ns / 1ps
`default_nettype none
// Converts one vertex element per cycle from its source layout to host layout
// while results are taken. An element is held in the input register, then the
// conversion logic writes the result register. Both registers advance together
// whenever the result register is empty or its result is taken, so one element
// per cycle flows through without gaps; result valid rises once the result
// register is written from the input register, and the result transfer follows.
// Every element gives exactly one result.
module vertex_element_format_converter_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  vefc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output vefc_pkg::out_item_t  out_data
);
  import vefc_pkg::*;

  logic      stg_valid_r, stg_valid_nxt;
  in_item_t  stg_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t conv;
  logic      advance;

  vefc_convert u_convert (
    .item_i (stg_data_r),
    .item_o (conv)
  );

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !stg_valid_r || advance;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = stg_valid_r;
      stg_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) stg_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stg_data_r <= in_data;
    if (advance && stg_valid_r) out_data_r <= conv;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
